// ===== rtl/core/vtu_pkg.sv =====
// Types and constants shared by the vertex transform unit core.
// Depends on nothing; imported by vertex_transform_unit_core.
package vtu_pkg;

   // kind codes on the request beat
   typedef enum logic [1:0] {
      KIND_ROTATE = 2'd0,
      KIND_NORMAL = 2'd1,
      KIND_POINT  = 2'd2,
      KIND_COORD  = 2'd3
   } vtu_kind_type;

   // status codes on the response beat
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_SAT    = 2'd1;
   localparam logic [1:0] STATUS_DIVZRO = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_ROW0 = 3'd0;
   localparam logic [2:0] CSR_ROW1 = 3'd1;
   localparam logic [2:0] CSR_ROW2 = 3'd2;
   localparam logic [2:0] CSR_ROW3 = 3'd3;
   localparam logic [2:0] CSR_QUAT = 3'd4;

   localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_1000;
   localparam logic [63:0] ROW1_RST = 64'h0000_0000_1000_0000;
   localparam logic [63:0] ROW2_RST = 64'h0000_1000_0000_0000;
   localparam logic [63:0] ROW3_RST = 64'h1000_0000_0000_0000;
   localparam logic [63:0] QUAT_RST = 64'h4000_0000_0000_0000;

   // one quotient bit per divider stage
   localparam int DIV_STAGES = 48;

   typedef struct packed {
      vtu_kind_type      kind;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } vtu_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic [1:0]         status;
   } vtu_rsp_type;

   // beat state carried through the divider stages
   typedef struct packed {
      vtu_kind_type      kind;
      logic [3:0][31:0]  res;
      logic              flag;
      logic              dz;
      logic [2:0]        neg;
      logic [31:0]       den;
      logic [2:0][79:0]  rq;
   } vtu_div_type;

endpackage

// ===== rtl/core/vertex_transform_unit_core.sv =====
// Vertex transform unit core: matrix, point, coord-divide and quaternion rotate.
// Depends on vtu_pkg (types, codes, reset values).
//
//  channel  | direction | handshake          | payload
//  req_     | in        | req_valid/ready    | vtu_req_type (kind, vec_x/y/z)
//  rsp_     | out       | rsp_valid/ready    | vtu_rsp_type (out_x/y/z/w, status)
//  csr_     | in        | csr_we             | csr_addr, csr_wdata (64 bits)
//
// One beat enters per cycle while the output is not held; the path is 4 arithmetic
// stages, 48 restoring divider stages of one quotient bit each and one output register.
// The divider chain sets the latency; every kind takes the same path.
// Synchronous reset clears all valid bits and loads the identity matrix and
// unit quaternion. When the output is held, every stage freezes together.
module vertex_transform_unit_core
   import vtu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  vtu_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output vtu_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   function automatic logic [32:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return {1'b1, 32'h7fff_ffff};
      end else if (v < -64'sd2147483648) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[31:0]};
   endfunction

   function automatic logic signed [15:0] lane(input logic [63:0] r, input int i);
      return r[16*i +: 16];
   endfunction

   // one restoring step: {rem, num/quotient} shifts left by one bit
   function automatic logic [79:0] div_step(input logic [79:0] rq, input logic [31:0] den);
      logic [32:0] rs;
      logic [32:0] df;
      rs = {rq[79:48], rq[47]};
      df = rs - {1'b0, den};
      if (!df[32]) begin
         return {df[31:0], rq[46:0], 1'b1};
      end
      return {rs[31:0], rq[46:0], 1'b0};
   endfunction

   // configuration registers
   logic [63:0] row_ff [4];
   logic [63:0] quat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW0_RST;
         row_ff[1] <= ROW1_RST;
         row_ff[2] <= ROW2_RST;
         row_ff[3] <= ROW3_RST;
         quat_ff   <= QUAT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ROW0: row_ff[0] <= csr_wdata;
            CSR_ROW1: row_ff[1] <= csr_wdata;
            CSR_ROW2: row_ff[2] <= csr_wdata;
            CSR_ROW3: row_ff[3] <= csr_wdata;
            CSR_QUAT: quat_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless the output beat is held
   logic pipe_en;
   logic rsp_valid_ff;
   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en;

   // stage 1: all first-level products
   logic                s1_v_ff;
   vtu_kind_type        s1_kind_ff;
   logic signed [47:0]  mp_ff [4][3];
   logic signed [47:0]  qp_ff [4][3];
   logic signed [47:0]  mp_in [4][3];
   logic signed [47:0]  qp_in [4][3];
   logic signed [31:0]  vin [3];

   always_comb begin
      vin[0] = req_data.vec_x;
      vin[1] = req_data.vec_y;
      vin[2] = req_data.vec_z;
      for (int j = 0; j < 4; j++) begin
         for (int r = 0; r < 3; r++) begin
            mp_in[j][r] = vin[r] * lane(row_ff[r], j);
            qp_in[j][r] = vin[r] * lane(quat_ff, j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_kind_ff <= req_data.kind;
         mp_ff      <= mp_in;
         qp_ff      <= qp_in;
      end
   end

   // stage 2: lane sums and first rounding
   logic               s2_v_ff;
   vtu_kind_type       s2_kind_ff;
   logic signed [38:0] a_ff [4];
   logic signed [36:0] t_ff [4];
   logic signed [38:0] a_in [4];
   logic signed [36:0] t_in [4];
   logic signed [50:0] macc [4];
   logic signed [50:0] tacc [4];
   logic signed [50:0] tmp51;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         macc[j] = mp_ff[j][0] + mp_ff[j][1] + mp_ff[j][2];
         if (s1_kind_ff != KIND_NORMAL) begin
            macc[j] = macc[j] + ($signed({{19{row_ff[3][16*j+15]}}, row_ff[3][16*j +: 16]})
                      <<< 16);
         end
         tmp51   = (macc[j] + 51'sd2048) >>> 12;
         a_in[j] = tmp51[38:0];
      end
      tacc[0] = qp_ff[3][0] + qp_ff[1][2] - qp_ff[2][1];
      tacc[1] = qp_ff[3][1] - qp_ff[0][2] + qp_ff[2][0];
      tacc[2] = qp_ff[3][2] + qp_ff[0][1] - qp_ff[1][0];
      tacc[3] = -qp_ff[0][0] - qp_ff[1][1] - qp_ff[2][2];
      for (int j = 0; j < 4; j++) begin
         tmp51   = (tacc[j] + 51'sd8192) >>> 14;
         t_in[j] = tmp51[36:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_kind_ff <= s1_kind_ff;
         a_ff       <= a_in;
         t_ff       <= t_in;
      end
   end

   // stage 3: second rotate products, matrix saturation and divide setup
   logic               s3_v_ff;
   vtu_kind_type       s3_kind_ff;
   logic signed [52:0] tq_ff [4][4];
   logic signed [52:0] tq_in [4][4];
   logic [31:0]        mo_ff [3];
   logic [31:0]        mo_in [3];
   logic               mflag_ff, mflag_in;
   logic               dz_ff, dz_in;
   logic [2:0]         neg_ff, neg_in;
   logic [47:0]        num_ff [3];
   logic [47:0]        num_in [3];
   logic [31:0]        den_ff, den_in;
   logic [32:0]        sa [4];
   logic [31:0]        mag [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            tq_in[i][j] = t_ff[i] * lane(quat_ff, j);
         end
      end
      for (int j = 0; j < 4; j++) begin
         sa[j]  = sat32(64'(a_ff[j]));
         mag[j] = sa[j][31] ? (~sa[j][31:0] + 32'd1) : sa[j][31:0];
      end
      mflag_in = sa[0][32] || sa[1][32] || sa[2][32];
      if (s2_kind_ff == KIND_COORD) begin
         mflag_in = mflag_in || sa[3][32];
      end
      dz_in  = (sa[3][31:0] == 32'd0);
      den_in = mag[3];
      for (int j = 0; j < 3; j++) begin
         mo_in[j]  = sa[j][31:0];
         num_in[j] = {mag[j], 16'd0};
         neg_in[j] = sa[j][31] ^ sa[3][31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_kind_ff <= s2_kind_ff;
         tq_ff      <= tq_in;
         mo_ff      <= mo_in;
         mflag_ff   <= mflag_in;
         dz_ff      <= dz_in;
         neg_ff     <= neg_in;
         num_ff     <= num_in;
         den_ff     <= den_in;
      end
   end

   // stage 4: rotate sums, rounding, saturation; merge into divider beat
   logic [DIV_STAGES:0] div_v_ff;
   vtu_div_type         div_ff [DIV_STAGES+1];
   vtu_div_type         div_in [DIV_STAGES+1];
   logic signed [54:0]  racc [4];
   logic signed [54:0]  tmp55;
   logic [32:0]         rs [4];

   always_comb begin
      racc[0] = -tq_ff[3][0] + tq_ff[0][3] - tq_ff[1][2] + tq_ff[2][1];
      racc[1] = -tq_ff[3][1] + tq_ff[0][2] + tq_ff[1][3] - tq_ff[2][0];
      racc[2] = -tq_ff[3][2] - tq_ff[0][1] + tq_ff[1][0] + tq_ff[2][3];
      racc[3] = tq_ff[3][3] + tq_ff[0][0] + tq_ff[1][1] + tq_ff[2][2];
      for (int j = 0; j < 4; j++) begin
         tmp55 = (racc[j] + 55'sd8192) >>> 14;
         rs[j] = sat32(64'($signed(tmp55[40:0])));
      end
      div_in[0].kind = s3_kind_ff;
      div_in[0].dz   = dz_ff;
      div_in[0].neg  = neg_ff;
      div_in[0].den  = den_ff;
      for (int j = 0; j < 3; j++) begin
         div_in[0].rq[j] = {32'd0, num_ff[j]};
      end
      if (s3_kind_ff == KIND_ROTATE) begin
         for (int j = 0; j < 4; j++) begin
            div_in[0].res[j] = rs[j][31:0];
         end
         div_in[0].flag = rs[0][32] || rs[1][32] || rs[2][32] || rs[3][32];
      end else begin
         for (int j = 0; j < 3; j++) begin
            div_in[0].res[j] = mo_ff[j];
         end
         div_in[0].res[3] = 32'd0;
         div_in[0].flag   = mflag_ff;
      end
      // divider stages
      for (int k = 1; k <= DIV_STAGES; k++) begin
         div_in[k] = div_ff[k-1];
         for (int j = 0; j < 3; j++) begin
            div_in[k].rq[j] = div_step(div_ff[k-1].rq[j], div_ff[k-1].den);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_v_ff <= '0;
      end else if (pipe_en) begin
         div_v_ff <= {div_v_ff[DIV_STAGES-1:0], s3_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         div_ff <= div_in;
      end
   end

   // output stage: quotient sign, saturation and status
   vtu_rsp_type rsp_ff, rsp_in;
   vtu_div_type dl;
   logic [32:0] qs [3];
   logic signed [63:0] qv;

   always_comb begin
      dl = div_ff[DIV_STAGES];
      for (int j = 0; j < 3; j++) begin
         qv = $signed({16'd0, dl.rq[j][47:0]});
         if (dl.neg[j]) begin
            qv = -qv;
         end
         qs[j] = sat32(qv);
      end
      rsp_in.out_x  = dl.res[0];
      rsp_in.out_y  = dl.res[1];
      rsp_in.out_z  = dl.res[2];
      rsp_in.out_w  = dl.res[3];
      rsp_in.status = dl.flag ? STATUS_SAT : STATUS_OK;
      if (dl.kind == KIND_COORD) begin
         if (dl.dz) begin
            rsp_in.out_x  = '0;
            rsp_in.out_y  = '0;
            rsp_in.out_z  = '0;
            rsp_in.out_w  = '0;
            rsp_in.status = STATUS_DIVZRO;
         end else begin
            rsp_in.out_x  = qs[0][31:0];
            rsp_in.out_y  = qs[1][31:0];
            rsp_in.out_z  = qs[2][31:0];
            rsp_in.out_w  = 32'sd65536;
            rsp_in.status = (dl.flag || qs[0][32] || qs[1][32] || qs[2][32]) ?
                            STATUS_SAT : STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= div_v_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // an accepted request beat lands in stage 1
   a_accept_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_v_ff)
      else $error("accepted beat did not enter stage 1");

   // a held output freezes the divider chain
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> (div_v_ff == $past(div_v_ff)))
      else $error("divider valid bits moved during a stall");

   // a coord beat that divides leaves with w of one
   a_coord_w: assert property (@(posedge clock) disable iff (reset)
      (pipe_en && div_v_ff[DIV_STAGES] && dl.kind == KIND_COORD && !dl.dz)
      |=> (rsp_valid && rsp_data.out_w == 32'sd65536))
      else $error("coord result w is not one");
`endif

endmodule

// ===== tb/sv/tb_vertex_transform_unit_core.sv =====
// Testbench for vertex_transform_unit_core: drives vector beats, predicts each
// result from a local fixed-point model and compares field by field.
// Depends on vtu_pkg and the vertex_transform_unit_core RTL.
module tb_vertex_transform_unit_core;
   import vtu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY    = 53;
   localparam int IDLE_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   vtu_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   vtu_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = CSR_ROW0;
   logic [63:0] csr_wdata = '0;

   // local copy of the configuration registers
   logic [63:0] row_reg [4];
   logic [63:0] quat_reg;

   vtu_rsp_type xform_expected [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          rsp_stall_on = 1'b1;

   vertex_transform_unit_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: cycles with no beat on any of the req, rsp or csr channels
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // -------- prediction --------
   function automatic longint sign16(input logic [63:0] r, input int i);
      logic signed [15:0] l;
      l = r[16*i +: 16];
      return longint'(l);
   endfunction

   function automatic longint round_sh(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic [31:0] clamp32(input longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'h7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic void hamilton(input longint a[4], input longint b[4],
                                    output longint r[4]);
      r[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
      r[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
      r[1] = a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0];
      r[2] = a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3];
   endfunction

   function automatic vtu_rsp_type transform_vertex(input vtu_req_type rq);
      vtu_rsp_type res;
      longint v[3], q[4], qc[4], p[4], t[4], r[4], a[4], acc;
      logic [31:0] o[4];
      bit sat;
      sat = 1'b0;
      v[0] = longint'(rq.vec_x);
      v[1] = longint'(rq.vec_y);
      v[2] = longint'(rq.vec_z);
      o = '{default: '0};
      res.status = STATUS_OK;
      if (rq.kind == KIND_ROTATE) begin
         for (int j = 0; j < 4; j++) q[j] = sign16(quat_reg, j);
         qc[0] = -q[0]; qc[1] = -q[1]; qc[2] = -q[2]; qc[3] = q[3];
         p[0] = v[0]; p[1] = v[1]; p[2] = v[2]; p[3] = 0;
         hamilton(q, p, t);
         for (int j = 0; j < 4; j++) t[j] = round_sh(t[j], 14);
         hamilton(t, qc, r);
         for (int j = 0; j < 4; j++) o[j] = clamp32(round_sh(r[j], 14), sat);
      end else begin
         for (int j = 0; j < 4; j++) begin
            acc = v[0]*sign16(row_reg[0], j) + v[1]*sign16(row_reg[1], j)
                + v[2]*sign16(row_reg[2], j);
            if (rq.kind != KIND_NORMAL) acc += sign16(row_reg[3], j) * 65536;
            a[j] = round_sh(acc, 12);
         end
         if (rq.kind != KIND_COORD) begin
            for (int j = 0; j < 3; j++) o[j] = clamp32(a[j], sat);
         end else begin
            for (int j = 0; j < 4; j++) begin
               o[j] = clamp32(a[j], sat);
               a[j] = longint'(signed'(o[j]));
            end
            if (a[3] == 0) begin
               o = '{default: '0};
               res.status = STATUS_DIVZRO;
            end else begin
               // SV division truncates toward zero
               for (int j = 0; j < 4; j++) o[j] = clamp32((a[j] * 65536) / a[3], sat);
            end
         end
      end
      if (res.status != STATUS_DIVZRO && sat) res.status = STATUS_SAT;
      res.out_x = o[0];
      res.out_y = o[1];
      res.out_z = o[2];
      res.out_w = o[3];
      return res;
   endfunction

   // -------- result checking and receiver stalls --------
   int rsp_wait = 0;
   always @(posedge clock) begin
      vtu_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (xform_expected.size() == 0) begin
            report_mismatch("unexpected beat", rsp_data.out_x, '0);
         end else begin
            want = xform_expected.pop_front();
            if (rsp_data.out_x !== want.out_x) report_mismatch("out_x", rsp_data.out_x, want.out_x);
            if (rsp_data.out_y !== want.out_y) report_mismatch("out_y", rsp_data.out_y, want.out_y);
            if (rsp_data.out_z !== want.out_z) report_mismatch("out_z", rsp_data.out_z, want.out_z);
            if (rsp_data.out_w !== want.out_w) report_mismatch("out_w", rsp_data.out_w, want.out_w);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
         end
      end
      // each beat draws its own ready delay
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!rsp_stall_on) begin
         rsp_ready <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         rsp_wait = $urandom_range(4);
         rsp_ready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= (rsp_wait == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // -------- stimulus helpers --------
   bit req_gap_on = 1'b1;

   task automatic send_vertex(input vtu_kind_type kind, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z);
      vtu_req_type rq;
      int gap;
      rq.kind  = kind;
      rq.vec_x = x;
      rq.vec_y = y;
      rq.vec_z = z;
      gap = req_gap_on ? $urandom_range(4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      xform_expected.push_back(transform_vertex(rq));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
   endtask

   // drain, then let the pipe empty before touching the registers
   task automatic wait_drained();
      end_burst();
      @(posedge clock);
      while (xform_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // one write beat, then csr_we is lowered before the next write
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      if (idx == CSR_QUAT) quat_reg = val;
      else row_reg[idx[1:0]] = val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
         3: return 32'($urandom_range(1) ? 1 : -1) * 32'h0001_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] rand_lanes(input bit q14);
      logic [63:0] r;
      for (int j = 0; j < 4; j++)
         case ($urandom_range(4))
            0: r[16*j +: 16] = 16'h7fff;
            1: r[16*j +: 16] = 16'h8000;
            2: r[16*j +: 16] = 16'h0000;
            3: r[16*j +: 16] = q14 ? 16'(($urandom_range(16384) - 8192))
                                   : 16'(($urandom_range(8192) - 4096));
            default: r[16*j +: 16] = 16'($urandom);
         endcase
      return r;
   endfunction

   task automatic random_vertices(input int n);
      for (int i = 0; i < n; i++)
         send_vertex(vtu_kind_type'($urandom_range(3)), rand_word(), rand_word(), rand_word());
   endtask

   // -------- tests --------
   task automatic test_reset_identity();
      send_vertex(KIND_ROTATE, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000);
      send_vertex(KIND_NORMAL, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
      send_vertex(KIND_POINT,  32'h0003_0000, 32'h0000_0001, 32'hffff_ffff);
      send_vertex(KIND_COORD,  32'h0004_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_vertex(KIND_ROTATE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      wait_drained();
   endtask

   task automatic test_directed_corners();
      // saturating matrix, divide by zero and a rotation that overflows
      write_reg(CSR_ROW0, 64'h7fff_7fff_7fff_7fff);
      write_reg(CSR_ROW1, 64'h8000_8000_8000_8000);
      write_reg(CSR_ROW2, 64'h1000_0000_0000_1000);
      write_reg(CSR_ROW3, 64'h0000_0000_0000_0000);
      write_reg(CSR_QUAT, 64'h7fff_7fff_7fff_7fff);
      send_vertex(KIND_NORMAL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_vertex(KIND_POINT,  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_vertex(KIND_COORD,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(KIND_COORD,  32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(KIND_COORD,  32'h0000_0000, 32'h0000_0000, 32'h0002_0000);
      send_vertex(KIND_ROTATE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      send_vertex(KIND_ROTATE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      wait_drained();
      write_reg(CSR_ROW3, 64'h8000_7fff_8000_7fff);
      write_reg(CSR_QUAT, 64'h8000_8000_8000_8000);
      send_vertex(KIND_POINT,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(KIND_COORD,  32'hffff_0000, 32'h0000_8000, 32'h0001_0000);
      send_vertex(KIND_ROTATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vertex(KIND_ROTATE, 32'h0001_0000, 32'hffff_ffff, 32'h0000_0001);
      wait_drained();
   endtask

   task automatic test_random_configs();
      for (int phase = 0; phase < 12; phase++) begin
         write_reg(CSR_ROW0, rand_lanes(1'b0));
         write_reg(CSR_ROW1, rand_lanes(1'b0));
         write_reg(CSR_ROW2, rand_lanes(1'b0));
         write_reg(CSR_ROW3, rand_lanes(1'b0));
         write_reg(CSR_QUAT, rand_lanes(1'b1));
         // some phases run at full rate on one side, and phase 11 on both sides
         req_gap_on   = (phase % 3 != 2);
         rsp_stall_on = (phase % 4 != 3);
         random_vertices(100);
         wait_drained();
      end
      req_gap_on   = 1'b1;
      rsp_stall_on = 1'b1;
   endtask

   initial begin
      row_reg[0] = ROW0_RST;
      row_reg[1] = ROW1_RST;
      row_reg[2] = ROW2_RST;
      row_reg[3] = ROW3_RST;
      quat_reg   = QUAT_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_identity();
      test_directed_corners();
      test_random_configs();
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
